// File: design/cafu_pkg.sv
`default_nettype none

package cafu_pkg;

   // Flag bit positions inside the 4-bit flag word
   localparam int unsigned FlagZ = 3;
   localparam int unsigned FlagN = 2;
   localparam int unsigned FlagH = 1;
   localparam int unsigned FlagC = 0;

   localparam int unsigned ReqBits  = 60;
   localparam int unsigned RspBits  = 29;
   localparam int unsigned ReqBytes = 8;
   localparam int unsigned RspBytes = 4;

   typedef enum logic [4:0] {
      MODE_ADD   = 5'd0,
      MODE_ADC   = 5'd1,
      MODE_SUB   = 5'd2,
      MODE_SBC   = 5'd3,
      MODE_AND   = 5'd4,
      MODE_XOR   = 5'd5,
      MODE_OR    = 5'd6,
      MODE_CP    = 5'd7,
      MODE_INC   = 5'd8,
      MODE_DEC   = 5'd9,
      MODE_RLC   = 5'd10,
      MODE_RRC   = 5'd11,
      MODE_RL    = 5'd12,
      MODE_RR    = 5'd13,
      MODE_SLA   = 5'd14,
      MODE_SRA   = 5'd15,
      MODE_SWAP  = 5'd16,
      MODE_SRL   = 5'd17,
      MODE_RLCA  = 5'd18,
      MODE_RRCA  = 5'd19,
      MODE_RLA   = 5'd20,
      MODE_RRA   = 5'd21,
      MODE_BIT   = 5'd22,
      MODE_RES   = 5'd23,
      MODE_SET   = 5'd24,
      MODE_DAA   = 5'd25,
      MODE_CPL   = 5'd26,
      MODE_SCF   = 5'd27,
      MODE_CCF   = 5'd28,
      MODE_ADD16 = 5'd29,
      MODE_SPE   = 5'd30
   } mode_type;

   // Request fields; first member is the top, so mode sits in the low bits
   typedef struct packed {
      logic [15:0] wide_b;
      logic [15:0] wide_a;
      logic [3:0]  flags_in;
      logic [2:0]  bit_index;
      logic [7:0]  operand;
      logic [7:0]  acc;
      logic [4:0]  mode;
   } req_type;

   typedef struct packed {
      logic        write_back;
      logic [3:0]  flags_out;
      logic [15:0] wide_result;
      logic [7:0]  result;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/cpu_alu_flag_unit_top.sv
`default_nettype none

// Channel   Dir  Ports                      Contents
// req       in   req_tvalid/tready/tdata    one ALU request: opcode, operands, flags
// rsp       out  rsp_tvalid/tready/tdata    result byte, wide result, flags, write-back
//
// Two register stages: the request register, then the ALU logic into the
// response register.
// One request is taken every cycle; nothing iterates, the only limit is the
// response side taking results.
// A stalled response holds its stage; the request stage keeps filling until it
// is full too. Synchronous reset empties both stages.

module cpu_alu_flag_unit_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [4:0] mode, [12:5] acc, [20:13] operand, [23:21] bit_index,
   // [27:24] flags_in, [43:28] wide_a, [59:44] wide_b, [63:60] zero
   input  wire  [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [7:0] result, [23:8] wide_result, [27:24] flags_out, [28] write_back,
   // [31:29] zero
   output logic [31:0] rsp_tdata
);
   import cafu_pkg::*;

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type alu_rsp;
   logic    rsp_open;
   logic    s1_load;
   logic    rsp_load;

   // a stage may load when it is empty or its content leaves this cycle
   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || rsp_open;
   assign s1_load    = req_tvalid && req_tready;
   assign rsp_load   = s1_valid_ff && rsp_open;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !rsp_open);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff <= req_type'(req_tdata[ReqBits-1:0]);
      end
      if (rsp_load) begin
         rsp_ff <= alu_rsp;
      end
   end

   cafu_alu u_alu (
      .req (s1_req_ff),
      .rsp (alu_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspBytes*8-RspBits){1'b0}}, rsp_ff};

`ifndef NO_ASSERTIONS
   // reset leaves both stages empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // a full request stage behind a stalled response must not take a request
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request stage overrun");

   // a response can only appear if the request stage held an item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) && rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response without request");

   // wide operations give a zero result byte and always store
   a_wide_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.wide_result != 16'd0))
         |-> (rsp_ff.result == 8'd0 && rsp_ff.write_back))
      else $error("wide result with byte result");
`endif

endmodule

`default_nettype wire

// File: design/cafu_alu.sv
`default_nettype none

module cafu_alu (
   input  cafu_pkg::req_type req,
   output cafu_pkg::rsp_type rsp
);
   import cafu_pkg::*;

   logic [7:0]  a;
   logic [7:0]  u;
   logic [3:0]  f;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  sum5;
   logic        add_ci;
   logic [7:0]  u_eff;
   logic        is_sub;
   logic [7:0]  inc_r;
   logic [7:0]  dec_r;
   logic [2:0]  sh_sel;
   logic [7:0]  sh_r;
   logic        sh_c;
   logic [7:0]  bit_mask;
   logic [7:0]  daa_adj;
   logic        daa_c;
   logic [7:0]  daa_r;
   logic [16:0] w16;
   logic [12:0] w12;
   logic [15:0] se;
   logic [15:0] spe_sum;
   logic [4:0]  spe_h;
   logic [8:0]  spe_c;
   logic [7:0]  res;
   logic [15:0] wide;
   logic [3:0]  fo;
   logic        wbk;

   assign a   = req.acc;
   assign u   = req.operand;
   assign f   = req.flags_in;
   assign cin = f[FlagC];

   // Shared 8-bit adder: subtract is a + ~u + !borrow
   assign is_sub = (req.mode == MODE_SUB) || (req.mode == MODE_SBC) || (req.mode == MODE_CP);
   assign u_eff  = is_sub ? ~u : u;
   always_comb begin
      unique case (req.mode)
         MODE_ADC: add_ci = cin;
         MODE_SUB: add_ci = 1'b1;
         MODE_CP:  add_ci = 1'b1;
         MODE_SBC: add_ci = ~cin;
         default:  add_ci = 1'b0;
      endcase
   end
   assign sum9 = {1'b0, a} + {1'b0, u_eff} + {8'd0, add_ci};
   assign sum5 = {1'b0, a[3:0]} + {1'b0, u_eff[3:0]} + {4'd0, add_ci};

   assign inc_r = a + 8'd1;
   assign dec_r = a - 8'd1;

   // CB shifts and the accumulator rotates share one shifter
   assign sh_sel = (req.mode >= MODE_RLCA) ? 3'(req.mode - MODE_RLCA)
                                           : 3'(req.mode - MODE_RLC);
   always_comb begin
      unique case (sh_sel)
         3'd0: begin sh_c = a[7]; sh_r = {a[6:0], a[7]}; end
         3'd1: begin sh_c = a[0]; sh_r = {a[0], a[7:1]}; end
         3'd2: begin sh_c = a[7]; sh_r = {a[6:0], cin}; end
         3'd3: begin sh_c = a[0]; sh_r = {cin, a[7:1]}; end
         3'd4: begin sh_c = a[7]; sh_r = {a[6:0], 1'b0}; end
         3'd5: begin sh_c = a[0]; sh_r = {a[7], a[7:1]}; end
         3'd6: begin sh_c = 1'b0; sh_r = {a[3:0], a[7:4]}; end
         default: begin sh_c = a[0]; sh_r = {1'b0, a[7:1]}; end
      endcase
   end

   assign bit_mask = 8'd1 << req.bit_index;

   // Decimal adjust
   always_comb begin
      daa_adj = 8'h00;
      daa_c   = 1'b0;
      if ((!f[FlagN] && (a > 8'h99)) || f[FlagC]) begin
         daa_adj = 8'h60;
         daa_c   = 1'b1;
      end
      if ((!f[FlagN] && (a[3:0] > 4'd9)) || f[FlagH]) begin
         daa_adj = daa_adj | 8'h06;
      end
   end
   assign daa_r = f[FlagN] ? (a - daa_adj) : (a + daa_adj);

   // Wide adders
   assign w16     = {1'b0, req.wide_a} + {1'b0, req.wide_b};
   assign w12     = {1'b0, req.wide_a[11:0]} + {1'b0, req.wide_b[11:0]};
   assign se      = {{8{u[7]}}, u};
   assign spe_sum = req.wide_a + se;
   assign spe_h   = {1'b0, req.wide_a[3:0]} + {1'b0, u[3:0]};
   assign spe_c   = {1'b0, req.wide_a[7:0]} + {1'b0, u};

   always_comb begin
      res  = a;
      wide = 16'd0;
      fo   = f;
      wbk  = 1'b1;
      unique case (req.mode)
         MODE_ADD, MODE_ADC: begin
            res = sum9[7:0];
            fo  = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
         end
         MODE_SUB, MODE_SBC: begin
            res = sum9[7:0];
            fo  = {sum9[7:0] == 8'd0, 1'b1, ~sum5[4], ~sum9[8]};
         end
         MODE_CP: begin
            wbk = 1'b0;
            fo  = {sum9[7:0] == 8'd0, 1'b1, ~sum5[4], ~sum9[8]};
         end
         MODE_AND: begin
            res = a & u;
            fo  = {(a & u) == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         MODE_XOR: begin
            res = a ^ u;
            fo  = {(a ^ u) == 8'd0, 3'b000};
         end
         MODE_OR: begin
            res = a | u;
            fo  = {(a | u) == 8'd0, 3'b000};
         end
         MODE_INC: begin
            res = inc_r;
            fo  = {inc_r == 8'd0, 1'b0, inc_r[3:0] == 4'h0, cin};
         end
         MODE_DEC: begin
            res = dec_r;
            fo  = {dec_r == 8'd0, 1'b1, dec_r[3:0] == 4'hF, cin};
         end
         MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
         MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
            res = sh_r;
            fo  = {sh_r == 8'd0, 2'b00, sh_c};
         end
         MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA: begin
            res = sh_r;
            fo  = {3'b000, sh_c};
         end
         MODE_BIT: begin
            wbk = 1'b0;
            fo  = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
         end
         MODE_RES: res = a & ~bit_mask;
         MODE_SET: res = a | bit_mask;
         MODE_DAA: begin
            res = daa_r;
            fo  = {daa_r == 8'd0, f[FlagN], 1'b0, daa_c};
         end
         MODE_CPL: begin
            res = ~a;
            fo  = {f[FlagZ], 1'b1, 1'b1, cin};
         end
         MODE_SCF: begin
            wbk = 1'b0;
            fo  = {f[FlagZ], 2'b00, 1'b1};
         end
         MODE_CCF: begin
            wbk = 1'b0;
            fo  = {f[FlagZ], 2'b00, ~cin};
         end
         MODE_ADD16: begin
            res  = 8'd0;
            wide = w16[15:0];
            fo   = {f[FlagZ], 1'b0, w12[12], w16[16]};
         end
         MODE_SPE: begin
            res  = 8'd0;
            wide = spe_sum;
            fo   = {2'b00, spe_h[4], spe_c[8]};
         end
         default: begin
            // unused opcode: no operation, nothing stored
            wbk = 1'b0;
         end
      endcase
   end

   assign rsp.result      = res;
   assign rsp.wide_result = wide;
   assign rsp.flags_out   = fo;
   assign rsp.write_back  = wbk;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import cafu_pkg::*;

   // Mode 31 has no enum member; the block treats it as a no-op
   localparam logic [4:0]  MODE_UNUSED = 5'd31;
   localparam int unsigned CycleLimit  = 200000;
   // Two register stages; a few spare cycles catch stray responses
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned ReqPad      = 8 * ReqBytes - ReqBits;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_PATTERN,
      STALL_RANDOM
   } stall_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   // Predicted responses, oldest first
   rsp_type     alu_results_due[$];
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;

   // Traffic shaping knobs, set per test
   bit          sender_gaps   = 1'b0;
   stall_type   stall_mode    = STALL_NONE;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [3:0]  stall_phase   = '0;
   int unsigned burst_left    = 0;
   // Flags of the last request, fed back so flag state chains like a real CPU
   logic [3:0]  chain_flags   = '0;

   cpu_alu_flag_unit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic [3:0] make_flags(input logic z, input logic n,
                                             input logic h, input logic c);
      logic [3:0] f;
      f        = '0;
      f[FlagZ] = z;
      f[FlagN] = n;
      f[FlagH] = h;
      f[FlagC] = c;
      return f;
   endfunction

   // CB shift group; returns {carry out, byte}
   function automatic logic [8:0] shift_byte(input logic [4:0] op, input logic [7:0] v,
                                             input logic cin);
      case (op)
         MODE_RLC:  return {v[7], v[6:0], v[7]};
         MODE_RRC:  return {v[0], v[0], v[7:1]};
         MODE_RL:   return {v[7], v[6:0], cin};
         MODE_RR:   return {v[0], cin, v[7:1]};
         MODE_SLA:  return {v[7], v[6:0], 1'b0};
         MODE_SRA:  return {v[0], v[7], v[7:1]};
         MODE_SWAP: return {1'b0, v[3:0], v[7:4]};
         default:   return {v[0], 1'b0, v[7:1]};
      endcase
   endfunction

   function automatic rsp_type predict_alu(input req_type r);
      rsp_type     o;
      logic [8:0]  sum9;
      logic [4:0]  sum5;
      logic [16:0] sum17;
      logic [12:0] sum13;
      logic [8:0]  shifted;
      logic [7:0]  adj;
      logic        carry_in;
      logic        take;
      logic        fn;
      carry_in      = r.flags_in[FlagC];
      fn            = r.flags_in[FlagN];
      o.result      = r.acc;
      o.wide_result = '0;
      o.flags_out   = r.flags_in;
      o.write_back  = 1'b1;
      case (r.mode)
         MODE_ADD, MODE_ADC: begin
            take        = (r.mode == MODE_ADC) && carry_in;
            sum9        = {1'b0, r.acc} + {1'b0, r.operand} + {8'd0, take};
            sum5        = {1'b0, r.acc[3:0]} + {1'b0, r.operand[3:0]} + {4'd0, take};
            o.result    = sum9[7:0];
            o.flags_out = make_flags(sum9[7:0] == 8'h00, 1'b0, sum5[4], sum9[8]);
         end
         MODE_SUB, MODE_SBC, MODE_CP: begin
            // bit 8 / bit 4 of the difference is the borrow
            take        = (r.mode == MODE_SBC) && carry_in;
            sum9        = {1'b0, r.acc} - {1'b0, r.operand} - {8'd0, take};
            sum5        = {1'b0, r.acc[3:0]} - {1'b0, r.operand[3:0]} - {4'd0, take};
            o.result    = sum9[7:0];
            o.flags_out = make_flags(sum9[7:0] == 8'h00, 1'b1, sum5[4], sum9[8]);
            if (r.mode == MODE_CP) begin
               o.result     = r.acc;
               o.write_back = 1'b0;
            end
         end
         MODE_AND: begin
            o.result    = r.acc & r.operand;
            o.flags_out = make_flags(o.result == 8'h00, 1'b0, 1'b1, 1'b0);
         end
         MODE_XOR: begin
            o.result    = r.acc ^ r.operand;
            o.flags_out = make_flags(o.result == 8'h00, 1'b0, 1'b0, 1'b0);
         end
         MODE_OR: begin
            o.result    = r.acc | r.operand;
            o.flags_out = make_flags(o.result == 8'h00, 1'b0, 1'b0, 1'b0);
         end
         MODE_INC: begin
            o.result    = r.acc + 8'd1;
            o.flags_out = make_flags(o.result == 8'h00, 1'b0, o.result[3:0] == 4'h0,
                                     carry_in);
         end
         MODE_DEC: begin
            o.result    = r.acc - 8'd1;
            o.flags_out = make_flags(o.result == 8'h00, 1'b1, o.result[3:0] == 4'hF,
                                     carry_in);
         end
         MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
         MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
            shifted     = shift_byte(r.mode, r.acc, carry_in);
            o.result    = shifted[7:0];
            o.flags_out = make_flags(shifted[7:0] == 8'h00, 1'b0, 1'b0, shifted[8]);
         end
         MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA: begin
            // same as the CB rotates, but Z always cleared
            shifted     = shift_byte(5'(r.mode - (MODE_RLCA - MODE_RLC)), r.acc, carry_in);
            o.result    = shifted[7:0];
            o.flags_out = make_flags(1'b0, 1'b0, 1'b0, shifted[8]);
         end
         MODE_BIT: begin
            o.flags_out  = make_flags(!r.acc[r.bit_index], 1'b0, 1'b1, carry_in);
            o.write_back = 1'b0;
         end
         MODE_RES: o.result = r.acc & ~(8'd1 << r.bit_index);
         MODE_SET: o.result = r.acc | (8'd1 << r.bit_index);
         MODE_DAA: begin
            adj  = '0;
            take = 1'b0;
            if ((!fn && r.acc > 8'h99) || carry_in) begin
               adj  = 8'h60;
               take = 1'b1;
            end
            if ((!fn && r.acc[3:0] > 4'd9) || r.flags_in[FlagH]) begin
               adj = adj | 8'h06;
            end
            o.result    = fn ? r.acc - adj : r.acc + adj;
            o.flags_out = make_flags(o.result == 8'h00, fn, 1'b0, take);
         end
         MODE_CPL: begin
            o.result    = ~r.acc;
            o.flags_out = r.flags_in | make_flags(1'b0, 1'b1, 1'b1, 1'b0);
         end
         MODE_SCF: begin
            o.flags_out  = make_flags(r.flags_in[FlagZ], 1'b0, 1'b0, 1'b1);
            o.write_back = 1'b0;
         end
         MODE_CCF: begin
            o.flags_out  = make_flags(r.flags_in[FlagZ], 1'b0, 1'b0, !carry_in);
            o.write_back = 1'b0;
         end
         MODE_ADD16: begin
            sum17         = {1'b0, r.wide_a} + {1'b0, r.wide_b};
            sum13         = {1'b0, r.wide_a[11:0]} + {1'b0, r.wide_b[11:0]};
            o.result      = '0;
            o.wide_result = sum17[15:0];
            o.flags_out   = make_flags(r.flags_in[FlagZ], 1'b0, sum13[12], sum17[16]);
         end
         MODE_SPE: begin
            // flags from the unsigned low-byte add, sum from the signed offset
            sum5          = {1'b0, r.wide_a[3:0]} + {1'b0, r.operand[3:0]};
            sum9          = {1'b0, r.wide_a[7:0]} + {1'b0, r.operand};
            o.result      = '0;
            o.wide_result = r.wide_a + {{8{r.operand[7]}}, r.operand};
            o.flags_out   = make_flags(1'b0, 1'b0, sum5[4], sum9[8]);
         end
         default: o.write_back = 1'b0;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: predict on request handshake, check on response handshake.
   // One process so the push and the pop cannot race.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : scoreboard
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            alu_results_due.push_back(predict_alu(req_type'(req_tdata[ReqBits-1:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RspBits-1:0]);
            if (alu_results_due.size() == 0) begin
               $error("unexpected response, tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = alu_results_due.pop_front();
               if (got.result !== want.result) begin
                  $error("result: expected %0h, actual %0h", want.result, got.result);
                  error_count++;
               end
               if (got.wide_result !== want.wide_result) begin
                  $error("wide_result: expected %0h, actual %0h",
                         want.wide_result, got.wide_result);
                  error_count++;
               end
               if (got.flags_out !== want.flags_out) begin
                  $error("flags_out: expected %0h, actual %0h",
                         want.flags_out, got.flags_out);
                  error_count++;
               end
               if (got.write_back !== want.write_back) begin
                  $error("write_back: expected %0h, actual %0h",
                         want.write_back, got.write_back);
                  error_count++;
               end
            end
            if (rsp_tdata[31:RspBits] !== '0) begin
               $error("tdata padding: expected 0, actual %0h", rsp_tdata[31:RspBits]);
               error_count++;
            end
         end
      end
   end

   // Receiver back-pressure. The pattern is refreshed each time the phase
   // counter wraps and is never all zero, so the pipe always drains.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 4'd1;
      if (stall_phase == 4'hF) begin
         stall_pattern <= 16'($urandom) | 16'h0101;
      end
      case (stall_mode)
         STALL_NONE:    rsp_tready <= 1'b1;
         STALL_PATTERN: rsp_tready <= stall_pattern[stall_phase];
         default:       rsp_tready <= ($urandom_range(2) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_request(input logic [4:0] mode, input logic [7:0] acc,
                                            input logic [7:0] operand,
                                            input logic [2:0] bit_index,
                                            input logic [3:0] flags,
                                            input logic [15:0] wide_a,
                                            input logic [15:0] wide_b);
      req_type r;
      r.mode      = mode;
      r.acc       = acc;
      r.operand   = operand;
      r.bit_index = bit_index;
      r.flags_in  = flags;
      r.wide_a    = wide_a;
      r.wide_b    = wide_b;
      return r;
   endfunction

   // Bytes and words biased toward carry and BCD boundaries
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(11))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h0F;
         3:       return 8'h80;
         4:       return 8'h99;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h0FFF;
         3:       return 16'h00FF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(39) == 0) begin
         r.mode = MODE_UNUSED;
      end else begin
         r.mode = 5'($urandom_range(MODE_SPE));
      end
      r.acc       = pick_byte();
      r.operand   = pick_byte();
      r.bit_index = 3'($urandom);
      r.flags_in  = 4'($urandom);
      r.wide_a    = pick_word();
      r.wide_b    = pick_word();
      return r;
   endfunction

   // Drive one request and hold it until taken. Valid stays high across
   // back-to-back requests; it only drops when a burst ends in a gap.
   task automatic send_request(input req_type r);
      int unsigned gap;
      req_tdata  <= {{ReqPad{1'b0}}, r};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sender_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(16);
            gap        = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_random_items(input int unsigned count);
      req_type     r;
      rsp_type     p;
      int unsigned i;
      for (i = 0; i < count; i++) begin
         r = random_request();
         if ($urandom_range(3) != 0) r.flags_in = chain_flags;
         send_request(r);
         p           = predict_alu(r);
         chain_flags = p.flags_out;
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Each opcode once, fields alternating all-zero and all-one
   task automatic test_every_mode();
      int unsigned m;
      logic        ones;
      sender_gaps = 1'b0;
      stall_mode  = STALL_NONE;
      for (m = MODE_ADD; m <= MODE_UNUSED; m++) begin
         ones = m[0];
         send_request(make_request(5'(m), {8{ones}}, {8{ones}}, {3{ones}}, {4{ones}},
                                   {16{ones}}, {16{ones}}));
      end
   endtask

   task automatic test_corner_values();
      sender_gaps = 1'b1;
      stall_mode  = STALL_PATTERN;
      // wrap to zero with half and full carry
      send_request(make_request(MODE_ADD, 8'hFF, 8'h01, 3'd0, 4'h0, 16'h0, 16'h0));
      // carry in alone makes the half carry
      send_request(make_request(MODE_ADC, 8'h0F, 8'h00, 3'd0, 4'h1, 16'h0, 16'h0));
      send_request(make_request(MODE_SUB, 8'h00, 8'h01, 3'd0, 4'h0, 16'h0, 16'h0));
      // borrow in brings the result to zero
      send_request(make_request(MODE_SBC, 8'h10, 8'h0F, 3'd0, 4'h1, 16'h0, 16'h0));
      send_request(make_request(MODE_CP,  8'h42, 8'h42, 3'd0, 4'h0, 16'h0, 16'h0));
      send_request(make_request(MODE_INC, 8'hFF, 8'h00, 3'd0, 4'h1, 16'h0, 16'h0));
      send_request(make_request(MODE_DEC, 8'h10, 8'h00, 3'd0, 4'h0, 16'h0, 16'h0));
      // decimal adjust after subtract, and after an add past 0x99
      send_request(make_request(MODE_DAA, 8'h45, 8'h00, 3'd0, 4'h7, 16'h0, 16'h0));
      send_request(make_request(MODE_DAA, 8'h9A, 8'h00, 3'd0, 4'h0, 16'h0, 16'h0));
      // 16-bit add: carry out of bit 11 only, then out of bit 15 with Z kept
      send_request(make_request(MODE_ADD16, 8'h00, 8'h00, 3'd0, 4'h8, 16'h0FFF, 16'h0001));
      send_request(make_request(MODE_ADD16, 8'h00, 8'h00, 3'd0, 4'h0, 16'hFFFF, 16'h0001));
      // SP plus offset: positive with carries, then most negative offset
      send_request(make_request(MODE_SPE, 8'h00, 8'h01, 3'd0, 4'hF, 16'hFFFF, 16'h0));
      send_request(make_request(MODE_SPE, 8'h00, 8'h80, 3'd0, 4'hF, 16'h0000, 16'h0));
      send_request(make_request(MODE_BIT, 8'h7F, 8'h00, 3'd7, 4'h0, 16'h0, 16'h0));
   endtask

   // Add or subtract two BCD bytes, then adjust with the flags that produced
   task automatic test_bcd_adjust(input int unsigned pairs);
      req_type     r;
      rsp_type     p;
      int unsigned i;
      sender_gaps = 1'b1;
      stall_mode  = STALL_PATTERN;
      for (i = 0; i < pairs; i++) begin
         r = make_request(MODE_ADD,
                          {4'($urandom_range(9)), 4'($urandom_range(9))},
                          {4'($urandom_range(9)), 4'($urandom_range(9))},
                          3'($urandom), 4'($urandom), pick_word(), pick_word());
         case ($urandom_range(3))
            0:       r.mode = MODE_ADD;
            1:       r.mode = MODE_ADC;
            2:       r.mode = MODE_SUB;
            default: r.mode = MODE_SBC;
         endcase
         send_request(r);
         p = predict_alu(r);
         send_request(make_request(MODE_DAA, p.result, pick_byte(), 3'($urandom),
                                   p.flags_out, pick_word(), pick_word()));
      end
   endtask

   task automatic test_flag_chains(input int unsigned count);
      sender_gaps = 1'b1;
      stall_mode  = STALL_PATTERN;
      send_random_items(count);
   endtask

   task automatic test_back_to_back(input int unsigned count);
      sender_gaps = 1'b0;
      stall_mode  = STALL_NONE;
      send_random_items(count);
   endtask

   task automatic test_slow_receiver(input int unsigned count);
      sender_gaps = 1'b1;
      stall_mode  = STALL_RANDOM;
      send_random_items(count);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_every_mode();
      test_corner_values();
      test_bcd_adjust(120);
      test_flag_chains(300);
      test_back_to_back(150);
      test_slow_receiver(150);
      req_tvalid <= 1'b0;
      // let the scoreboard log the last request before checking the queue
      @(posedge clock);
      while (alu_results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
